// ===== hw/rtl/tangent_to_param_velocity_unit_assert.svh =====
`ifndef TANGENT_TO_PARAM_VELOCITY_UNIT_ASSERT_SVH
`define TANGENT_TO_PARAM_VELOCITY_UNIT_ASSERT_SVH

// Both macros expect signals named clock and reset in the enclosing scope.
`define TPV_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tangent unit: implication check failed");

`define TPV_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tangent unit: next-cycle check failed");

`endif

// ===== hw/rtl/tpv_pkg.sv =====
package tpv_pkg;

   localparam int CW = 24;
   localparam int FB = 16;
   localparam int QW = 32;
   localparam int PW = 2 * CW;
   localparam int XW = 2 * CW + 1;
   localparam int LOW = (XW + 1) / 2;
   localparam int HIW = XW - LOW;
   localparam int SW = 2 * XW + 2;
   localparam int DW = SW - 1;
   localparam int RW = DW + QW + 1;
   localparam int QN = QW + 1;
   localparam int LW = (SW > 4 * FB + QW) ? SW : 4 * FB + QW;

   typedef logic signed [CW-1:0] comp_type;
   typedef logic signed [PW-1:0] prod_type;
   typedef logic signed [XW-1:0] cross_type;
   typedef logic signed [SW-1:0] sum_type;

   typedef struct packed {
      logic          degen;
      logic          neg_u;
      logic          neg_v;
      logic [RW-1:0] rem_u;
      logic [RW-1:0] rem_v;
      logic [RW-1:0] den_sh;
      logic [QN-1:0] q_u;
      logic [QN-1:0] q_v;
   } div_type;

   localparam logic [QN-1:0] NEG_LIMIT = QN'(1) << (QW - 1);
   localparam logic [QN-1:0] POS_LIMIT = NEG_LIMIT - QN'(1);
   localparam logic [QW-1:0] MIN_RATE = QW'(1) << (QW - 1);
   localparam logic [QW-1:0] MAX_RATE = MIN_RATE - QW'(1);

endpackage

// ===== hw/rtl/tpv_cross.sv =====
module tpv_cross import tpv_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      advance,
   input  logic      in_valid,
   input  comp_type  dir [3],
   input  comp_type  du [3],
   input  comp_type  dv [3],
   output logic      out_valid,
   output cross_type c [3],
   output cross_type dxv [3],
   output cross_type uxd [3]
);

   comp_type  opa [3][3];
   comp_type  opb [3][3];
   prod_type  pa_in [3][3];
   prod_type  pb_in [3][3];
   prod_type  pa_ff [3][3];
   prod_type  pb_ff [3][3];
   cross_type x_in [3][3];
   cross_type x_ff [3][3];
   logic      va_ff;
   logic      vb_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         opa[0][i] = du[i];
         opb[0][i] = dv[i];
         opa[1][i] = dir[i];
         opb[1][i] = dv[i];
         opa[2][i] = du[i];
         opb[2][i] = dir[i];
      end
   end

   for (genvar k = 0; k < 3; k++) begin : g_cross
      for (genvar i = 0; i < 3; i++) begin : g_comp
         localparam int I1 = (i + 1) % 3;
         localparam int I2 = (i + 2) % 3;
         assign pa_in[k][i] = opa[k][I1] * opb[k][I2];
         assign pb_in[k][i] = opa[k][I2] * opb[k][I1];
         assign x_in[k][i]  = XW'(pa_ff[k][i]) - XW'(pb_ff[k][i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else if (advance) begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pa_ff <= pa_in;
         pb_ff <= pb_in;
         x_ff  <= x_in;
      end
   end

   assign out_valid = vb_ff;
   assign c         = x_ff[0];
   assign dxv       = x_ff[1];
   assign uxd       = x_ff[2];

endmodule

// ===== hw/rtl/tpv_dot.sv =====
module tpv_dot import tpv_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      advance,
   input  logic      in_valid,
   input  cross_type c [3],
   input  cross_type dxv [3],
   input  cross_type uxd [3],
   output logic      out_valid,
   output sum_type   cc,
   output sum_type   num_u,
   output sum_type   num_v
);

   cross_type                 opa [9];
   cross_type                 opb [9];
   logic signed [2*HIW-1:0]   hh_in [9];
   logic signed [HIW+LOW:0]   hl_in [9];
   logic signed [HIW+LOW:0]   lh_in [9];
   logic [2*LOW-1:0]          ll_in [9];
   logic signed [2*HIW-1:0]   hh_ff [9];
   logic signed [HIW+LOW:0]   hl_ff [9];
   logic signed [HIW+LOW:0]   lh_ff [9];
   logic [2*LOW-1:0]          ll_ff [9];
   sum_type                   prod_in [9];
   sum_type                   prod_ff [9];
   sum_type                   cc_ff;
   sum_type                   nu_ff;
   sum_type                   nv_ff;
   logic                      vc_ff;
   logic                      vd_ff;
   logic                      ve_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         opa[i]     = c[i];
         opb[i]     = c[i];
         opa[3 + i] = dxv[i];
         opb[3 + i] = c[i];
         opa[6 + i] = uxd[i];
         opb[6 + i] = c[i];
      end
   end

   // Each wide product is split into high and low halves over two stages.
   for (genvar m = 0; m < 9; m++) begin : g_mul
      assign hh_in[m] = $signed(opa[m][XW-1:LOW]) * $signed(opb[m][XW-1:LOW]);
      assign hl_in[m] = $signed(opa[m][XW-1:LOW]) * $signed({1'b0, opb[m][LOW-1:0]});
      assign lh_in[m] = $signed({1'b0, opa[m][LOW-1:0]}) * $signed(opb[m][XW-1:LOW]);
      assign ll_in[m] = opa[m][LOW-1:0] * opb[m][LOW-1:0];
      assign prod_in[m] = (SW'(hh_ff[m]) << (2 * LOW)) + (SW'(hl_ff[m]) << LOW)
                        + (SW'(lh_ff[m]) << LOW) + SW'(ll_ff[m]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
         ve_ff <= 1'b0;
      end else if (advance) begin
         vc_ff <= in_valid;
         vd_ff <= vc_ff;
         ve_ff <= vd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         hh_ff   <= hh_in;
         hl_ff   <= hl_in;
         lh_ff   <= lh_in;
         ll_ff   <= ll_in;
         prod_ff <= prod_in;
         cc_ff   <= prod_ff[0] + prod_ff[1] + prod_ff[2];
         nu_ff   <= prod_ff[3] + prod_ff[4] + prod_ff[5];
         nv_ff   <= prod_ff[6] + prod_ff[7] + prod_ff[8];
      end
   end

   assign out_valid = ve_ff;
   assign cc        = cc_ff;
   assign num_u     = nu_ff;
   assign num_v     = nv_ff;

endmodule

// ===== hw/rtl/tpv_div_step.sv =====
module tpv_div_step import tpv_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    advance,
   input  logic    in_valid,
   input  div_type in_data,
   output logic    out_valid,
   output div_type out_data
);

   div_type data_in;
   div_type data_ff;
   logic    valid_ff;
   logic    ge_u;
   logic    ge_v;

   always_comb begin
      ge_u           = in_data.rem_u >= in_data.den_sh;
      ge_v           = in_data.rem_v >= in_data.den_sh;
      data_in        = in_data;
      data_in.rem_u  = ge_u ? in_data.rem_u - in_data.den_sh : in_data.rem_u;
      data_in.rem_v  = ge_v ? in_data.rem_v - in_data.den_sh : in_data.rem_v;
      data_in.q_u    = {in_data.q_u[QN-2:0], ge_u};
      data_in.q_v    = {in_data.q_v[QN-2:0], ge_v};
      data_in.den_sh = in_data.den_sh >> 1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== hw/rtl/tangent_to_param_velocity_unit.sv =====
// Solves d = rate_u * du + rate_v * dv by Cramer's rule and returns both rates in signed
// Q16.16, truncated towards zero and saturated, with a degenerate flag when the squared
// cross product of the tangents falls below csr_wr_data's threshold. One request enters
// every cycle while the pipeline is not stalled: two stages form the
// cross products, three form the split dot products, one prepares the division and 33
// restoring steps, one per quotient bit, produce both quotients before the output stage.
// A held response stalls the whole pipeline, so req_stall follows rsp_valid and rsp_stall.
module tangent_to_param_velocity_unit import tpv_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic signed [CW-1:0] req_dir_x,
   input  logic signed [CW-1:0] req_dir_y,
   input  logic signed [CW-1:0] req_dir_z,
   input  logic signed [CW-1:0] req_du_x,
   input  logic signed [CW-1:0] req_du_y,
   input  logic signed [CW-1:0] req_du_z,
   input  logic signed [CW-1:0] req_dv_x,
   input  logic signed [CW-1:0] req_dv_y,
   input  logic signed [CW-1:0] req_dv_z,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic signed [QW-1:0] rsp_rate_u,
   output logic signed [QW-1:0] rsp_rate_v,
   output logic                 rsp_degenerate,
   output logic                 rsp_saturated,
   input  logic                 csr_wr_en,
   input  logic [QW-1:0]        csr_wr_data
);

   logic          advance;
   logic [QW-1:0] min_ff;
   comp_type      dir_w [3];
   comp_type      du_w [3];
   comp_type      dv_w [3];
   logic          x_valid;
   cross_type     c_w [3];
   cross_type     dxv_w [3];
   cross_type     uxd_w [3];
   logic          s_valid;
   sum_type       cc_w;
   sum_type       nu_w;
   sum_type       nv_w;
   logic [SW-1:0] mag_u;
   logic [SW-1:0] mag_v;
   div_type       prep_in;
   logic          dvalid [QN+1];
   div_type       ddata [QN+1];
   div_type       last;
   logic          sat_u;
   logic          sat_v;
   logic [QW-1:0] rate_u_in;
   logic [QW-1:0] rate_v_in;
   logic          valid_ff;
   logic [QW-1:0] rate_u_ff;
   logic [QW-1:0] rate_v_ff;
   logic          degen_ff;
   logic          sat_ff;
   logic          pvalid_ff;
   div_type       prep_ff;

   assign advance   = !(valid_ff && rsp_stall);
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= QW'(1);
      end else if (csr_wr_en) begin
         min_ff <= csr_wr_data;
      end
   end

   assign dir_w[0] = req_dir_x;
   assign dir_w[1] = req_dir_y;
   assign dir_w[2] = req_dir_z;
   assign du_w[0]  = req_du_x;
   assign du_w[1]  = req_du_y;
   assign du_w[2]  = req_du_z;
   assign dv_w[0]  = req_dv_x;
   assign dv_w[1]  = req_dv_y;
   assign dv_w[2]  = req_dv_z;

   tpv_cross u_cross (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .dir       (dir_w),
      .du        (du_w),
      .dv        (dv_w),
      .out_valid (x_valid),
      .c         (c_w),
      .dxv       (dxv_w),
      .uxd       (uxd_w)
   );

   tpv_dot u_dot (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (x_valid),
      .c         (c_w),
      .dxv       (dxv_w),
      .uxd       (uxd_w),
      .out_valid (s_valid),
      .cc        (cc_w),
      .num_u     (nu_w),
      .num_v     (nv_w)
   );

   always_comb begin
      mag_u          = nu_w[SW-1] ? SW'(-nu_w) : SW'(nu_w);
      mag_v          = nv_w[SW-1] ? SW'(-nv_w) : SW'(nv_w);
      prep_in.degen  = (cc_w == '0) || (LW'(cc_w) < (LW'(min_ff) << (4 * FB)));
      prep_in.neg_u  = nu_w[SW-1];
      prep_in.neg_v  = nv_w[SW-1];
      prep_in.rem_u  = RW'(mag_u) << FB;
      prep_in.rem_v  = RW'(mag_v) << FB;
      prep_in.den_sh = RW'(cc_w[DW-1:0]) << QW;
      prep_in.q_u    = '0;
      prep_in.q_v    = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pvalid_ff <= 1'b0;
      end else if (advance) begin
         pvalid_ff <= s_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prep_ff <= prep_in;
      end
   end

   assign dvalid[0] = pvalid_ff;
   assign ddata[0]  = prep_ff;

   for (genvar s = 0; s < QN; s++) begin : g_step
      tpv_div_step u_step (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (dvalid[s]),
         .in_data   (ddata[s]),
         .out_valid (dvalid[s + 1]),
         .out_data  (ddata[s + 1])
      );
   end

   assign last = ddata[QN];

   always_comb begin
      if (last.neg_u) begin
         sat_u     = last.q_u > NEG_LIMIT;
         rate_u_in = sat_u ? MIN_RATE : QW'(-last.q_u[QW-1:0]);
      end else begin
         sat_u     = last.q_u > POS_LIMIT;
         rate_u_in = sat_u ? MAX_RATE : last.q_u[QW-1:0];
      end
      if (last.neg_v) begin
         sat_v     = last.q_v > NEG_LIMIT;
         rate_v_in = sat_v ? MIN_RATE : QW'(-last.q_v[QW-1:0]);
      end else begin
         sat_v     = last.q_v > POS_LIMIT;
         rate_v_in = sat_v ? MAX_RATE : last.q_v[QW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= dvalid[QN];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rate_u_ff <= last.degen ? '0 : rate_u_in;
         rate_v_ff <= last.degen ? '0 : rate_v_in;
         degen_ff  <= last.degen;
         sat_ff    <= !last.degen && (sat_u || sat_v);
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_rate_u     = rate_u_ff;
   assign rsp_rate_v     = rate_v_ff;
   assign rsp_degenerate = degen_ff;
   assign rsp_saturated  = sat_ff;

endmodule

// ===== hw/rtl/tpv_checker.sv =====
`include "tangent_to_param_velocity_unit_assert.svh"

module tpv_checker import tpv_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic signed [QW-1:0] rsp_rate_u,
   input logic signed [QW-1:0] rsp_rate_v,
   input logic                 rsp_degenerate,
   input logic                 rsp_saturated
);

   `TPV_ASSERT_IMPLY(a_degen_zero, rsp_valid && rsp_degenerate,
      rsp_rate_u == '0 && rsp_rate_v == '0 && !rsp_saturated)

   `TPV_ASSERT_IMPLY(a_sat_clipped, rsp_valid && rsp_saturated,
      rsp_rate_u == MAX_RATE || rsp_rate_u == MIN_RATE ||
      rsp_rate_v == MAX_RATE || rsp_rate_v == MIN_RATE)

   `TPV_ASSERT_IMPLY(a_stall_follows, 1'b1, req_stall == (rsp_valid && rsp_stall))

   `TPV_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_rate_u) && $stable(rsp_rate_v) && $stable(rsp_saturated))

endmodule

bind tangent_to_param_velocity_unit tpv_checker u_tpv_checker (.*);

// ===== verif/tangent_to_param_velocity_unit_tb.sv =====
`timescale 1ns / 1ps

module tangent_to_param_velocity_unit_tb;
   import tpv_pkg::*;

   typedef logic signed [199:0] wide_type;

   typedef struct packed {
      comp_type dx, dy, dz, ux, uy, uz, vx, vy, vz;
   } query_type;

   typedef struct packed {
      logic [QW-1:0] rate_u;
      logic [QW-1:0] rate_v;
      logic          degenerate;
      logic          saturated;
   } velocity_type;

   logic             clock = 0;
   logic             reset = 1;
   logic             req_valid = 0;
   logic             req_stall;
   query_type        req_q = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1;
   logic [QW-1:0]    rsp_rate_u, rsp_rate_v;
   logic             rsp_degenerate, rsp_saturated;
   logic             csr_wr_en = 0;
   logic [QW-1:0]    csr_wr_data = '0;

   query_type        pending_queries[$];
   velocity_type     expected_velocities[$];
   logic [QW-1:0]    norm_threshold = 1;
   int               errors = 0;
   int               cycle = 0;
   int               idle_cycles = 0;
   int               hold_request = 0;
   int               hold_left = 0;
   logic             stimulus_done = 0;

   tangent_to_param_velocity_unit DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_dir_x(req_q.dx), .req_dir_y(req_q.dy), .req_dir_z(req_q.dz),
      .req_du_x(req_q.ux), .req_du_y(req_q.uy), .req_du_z(req_q.uz),
      .req_dv_x(req_q.vx), .req_dv_y(req_q.vy), .req_dv_z(req_q.vz),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_rate_u(rsp_rate_u), .rsp_rate_v(rsp_rate_v),
      .rsp_degenerate(rsp_degenerate), .rsp_saturated(rsp_saturated),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always #10 clock = ~clock;

   function automatic logic [QW-1:0] clip_quotient(wide_type num, wide_type den,
                                                   inout logic sat);
      logic     neg;
      wide_type mag;
      wide_type q;
      neg = num < 0;
      mag = neg ? -num : num;
      q = (mag <<< FB) / den;
      if (neg) begin
         if (q > wide_type'(64'h8000_0000)) begin
            sat = 1;
            return MIN_RATE;
         end
         return -q[QW-1:0];
      end
      if (q > wide_type'(64'h7FFF_FFFF)) begin
         sat = 1;
         return MAX_RATE;
      end
      return q[QW-1:0];
   endfunction

   function automatic velocity_type solve_velocity(query_type r);
      wide_type     dx, dy, dz, ux, uy, uz, vx, vy, vz;
      wide_type     cx, cy, cz, ax, ay, az, bx, by, bz, cc;
      velocity_type o;
      logic         sat;
      dx = r.dx; dy = r.dy; dz = r.dz;
      ux = r.ux; uy = r.uy; uz = r.uz;
      vx = r.vx; vy = r.vy; vz = r.vz;
      cx = uy * vz - uz * vy;
      cy = uz * vx - ux * vz;
      cz = ux * vy - uy * vx;
      cc = cx * cx + cy * cy + cz * cz;
      o = '0;
      sat = 0;
      if (cc == 0 || cc < (wide_type'({1'b0, norm_threshold}) <<< (4 * FB))) begin
         o.degenerate = 1;
         return o;
      end
      ax = dy * vz - dz * vy;
      ay = dz * vx - dx * vz;
      az = dx * vy - dy * vx;
      bx = uy * dz - uz * dy;
      by = uz * dx - ux * dz;
      bz = ux * dy - uy * dx;
      o.rate_u = clip_quotient(ax * cx + ay * cy + az * cz, cc, sat);
      o.rate_v = clip_quotient(bx * cx + by * cy + bz * cz, cc, sat);
      o.saturated = sat;
      return o;
   endfunction

   function automatic logic idle_now();
      if (cycle > 4000 && cycle < 7000) begin
         return 0;
      end
      return $urandom_range(99) < 23;
   endfunction

   // Request driver: a valid request is held until the block takes it.
   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (reset) begin
         req_valid <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_velocities.push_back(solve_velocity(req_q));
         end
         if (!req_valid || !req_stall) begin
            if (pending_queries.size() > 0 && !idle_now()) begin
               req_q <= pending_queries.pop_front();
               req_valid <= 1;
            end else begin
               req_valid <= 0;
            end
         end
      end
   end

   // Response monitor, including the long hold-off.
   always @(posedge clock) begin
      velocity_type got, want;
      if (reset) begin
         rsp_stall <= 1;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_rate_u, rsp_rate_v, rsp_degenerate, rsp_saturated};
            if (expected_velocities.size() == 0) begin
               errors = errors + 1;
               if (errors <= 10) begin
                  $display("Unexpected response %h", got);
               end
            end else begin
               want = expected_velocities.pop_front();
               if (got !== want) begin
                  errors = errors + 1;
                  if (errors <= 10) begin
                     $display("Mismatch: expected u=%h v=%h dg=%b sat=%b, got u=%h v=%h dg=%b sat=%b",
                        want.rate_u, want.rate_v, want.degenerate, want.saturated,
                        got.rate_u, got.rate_v, got.degenerate, got.saturated);
                  end
               end
            end
         end
         if (hold_request > 0 && hold_left == 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_stall <= 1;
         end else begin
            rsp_stall <= idle_now();
         end
      end
   end

   // Watchdog on cycles without any accepted request or response.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (!stimulus_done) begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles > 3000) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   function automatic comp_type pick_component(int mode);
      case (mode)
         0: return comp_type'($urandom);
         1: return comp_type'($signed($urandom_range(131072)) - 65536);
         default: return comp_type'($signed($urandom_range(2048)) - 1024);
      endcase
   endfunction

   function automatic query_type random_query();
      query_type r;
      int        mode;
      mode = $urandom_range(2);
      r = {pick_component(mode), pick_component(mode), pick_component(mode),
           pick_component(mode), pick_component(mode), pick_component(mode),
           pick_component(mode), pick_component(mode), pick_component(mode)};
      if ($urandom_range(9) == 0) begin
         // Nearly parallel tangents.
         r.vx = r.ux + comp_type'($urandom_range(3));
         r.vy = r.uy;
         r.vz = r.uz - comp_type'($urandom_range(1));
      end
      return r;
   endfunction

   task automatic drain();
      do @(posedge clock);
      while (pending_queries.size() > 0 || req_valid || expected_velocities.size() > 0);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_threshold(logic [QW-1:0] value);
      csr_wr_en <= 1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 0;
      norm_threshold = value;
      @(posedge clock);
   endtask

   task automatic queue_random(int count);
      repeat (count) pending_queries.push_back(random_query());
   endtask

   localparam comp_type ONE = comp_type'(1 << FB);
   localparam comp_type CMAX = comp_type'({1'b0, {(CW-1){1'b1}}});
   localparam comp_type CMIN = comp_type'({1'b1, {(CW-1){1'b0}}});

   initial begin
      repeat (3) @(posedge clock);
      reset <= 0;
      // Directed requests under the reset threshold.
      pending_queries.push_back('0);
      pending_queries.push_back({ONE, ONE, ONE, ONE, 24'sd0, 24'sd0, 24'sd0, ONE, 24'sd0});
      pending_queries.push_back({CMAX, CMIN, CMAX, CMAX, 24'sd0, 24'sd0, 24'sd0, CMAX, 24'sd0});
      pending_queries.push_back({CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMAX, CMIN, CMAX});
      pending_queries.push_back({CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN});
      pending_queries.push_back({CMIN, CMAX, CMIN, CMIN, CMAX, 24'sd0, CMAX, CMIN, 24'sd0});
      pending_queries.push_back({CMAX, CMAX, CMAX, 24'sd1, 24'sd0, 24'sd0, 24'sd0, 24'sd1, 24'sd0});
      pending_queries.push_back({CMIN, CMIN, CMIN, 24'sd1, 24'sd0, 24'sd0, 24'sd0, 24'sd1, 24'sd0});
      pending_queries.push_back({ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE});
      pending_queries.push_back({ONE, -ONE, ONE, 24'sd256, 24'sd0, 24'sd0, 24'sd0, 24'sd256,
                                 24'sd0});
      pending_queries.push_back({-ONE, ONE, -ONE, ONE, ONE, 24'sd0, -ONE, ONE, 24'sd0});
      drain();
      write_threshold(0);
      pending_queries.push_back('0);
      pending_queries.push_back({ONE, ONE, ONE, 24'sd1, 24'sd0, 24'sd0, 24'sd0, 24'sd1, 24'sd0});
      pending_queries.push_back({ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE});
      queue_random(500);
      hold_request = 300;
      drain();
      write_threshold('1);
      pending_queries.push_back({CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMAX, CMIN, CMAX});
      queue_random(150);
      drain();
      write_threshold(QW'($urandom_range(16)));
      queue_random(450);
      drain();
      write_threshold(1);
      queue_random(450);
      drain();
      stimulus_done = 1;
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/tpv_pkg.sv
hw/rtl/tpv_cross.sv
hw/rtl/tpv_dot.sv
hw/rtl/tpv_div_step.sv
hw/rtl/tangent_to_param_velocity_unit.sv
hw/rtl/tpv_checker.sv
verif/tangent_to_param_velocity_unit_tb.sv
